// File: hdl/fpu_pkg.sv
// Shared types, constants and helper functions for the floating-point unit.
// No dependencies; imported by every module of the unit.
package fpu_pkg;

  localparam int SIG_W      = 24;              // internal significand, hidden bit at msb
  localparam int EXP_W      = 11;              // signed internal exponent
  localparam int RES_W      = 51;              // unrounded result significand
  localparam int ALIGN_W    = 50;              // addend alignment window
  localparam int GUARD_W    = ALIGN_W - SIG_W; // extra bits below the addend
  localparam int PROD_W     = 2 * SIG_W;
  localparam int QUO_W      = 28;              // quotient bits before the sticky bit
  localparam int DIV_BITS   = 2;               // quotient bits per divider stage
  localparam int DIV_STAGES = QUO_W / DIV_BITS;
  localparam int MAN_SP     = 23;
  localparam int MAN_HP     = 10;

  localparam logic FMT_HALF   = 1'b0;
  localparam logic FMT_SINGLE = 1'b1;

  localparam logic [0:0] REG_FORMAT   = 1'b0;
  localparam logic [0:0] REG_ROUNDING = 1'b1;

  localparam logic [31:0] QNAN_SP = 32'h7FC0_0000;
  localparam logic [31:0] QNAN_HP = 32'h0000_7E00;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RM_RTZ = 2'd0,
    RM_RNE = 2'd1,
    RM_RUP = 2'd2,
    RM_RDN = 2'd3
  } rm_t;

  typedef logic signed [EXP_W-1:0] exp_t;

  // Operand after field extraction; e23 is the exponent of significand bit 23.
  typedef struct packed {
    logic             sign;
    logic             nan;
    logic             inf;
    logic             zero;
    logic [SIG_W-1:0] sig;
    exp_t             e23;
  } unpacked_t;

  // Control that travels with every item.
  typedef struct packed {
    logic        fmt;
    rm_t         rm;
    op_t         op;
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    exp_t        e_top;   // exponent of bit RES_W-1 of the result significand
  } ctl_t;

  typedef struct packed {
    logic [SIG_W-1:0] divisor;
    logic [SIG_W:0]   rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [RES_W-1:0] sig;
  } rnd_in_t;

  function automatic unpacked_t unpack_op(input logic fmt, input logic [31:0] bits);
    unpacked_t  u;
    logic [7:0] fld;
    logic [7:0] fld_eff;
    logic [7:0] fmax;
    logic [7:0] bias;
    logic [22:0] frac;
    if (fmt == FMT_SINGLE) begin
      fld    = bits[30:23];
      frac   = bits[22:0];
      u.sign = bits[31];
      fmax   = 8'd255;
      bias   = 8'd127;
    end else begin
      fld    = {3'b000, bits[14:10]};
      frac   = {bits[9:0], 13'd0};
      u.sign = bits[15];
      fmax   = 8'd31;
      bias   = 8'd15;
    end
    u.nan   = (fld == fmax) && (frac != 23'd0);
    u.inf   = (fld == fmax) && (frac == 23'd0);
    u.zero  = (fld == 8'd0) && (frac == 23'd0);
    u.sig   = {fld != 8'd0, frac};
    fld_eff = (fld == 8'd0) ? 8'd1 : fld;
    u.e23   = exp_t'({3'b000, fld_eff}) - exp_t'({3'b000, bias});
    return u;
  endfunction

  function automatic logic [4:0] lzc_sig(input logic [SIG_W-1:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < SIG_W; i++) begin
      if (v[i]) n = 5'(SIG_W - 1 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc_res(input logic [RES_W-1:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < RES_W; i++) begin
      if (v[i]) n = 6'(RES_W - 1 - i);
    end
    return n;
  endfunction

  function automatic logic [31:0] qnan_bits(input logic fmt);
    return (fmt == FMT_SINGLE) ? QNAN_SP : QNAN_HP;
  endfunction

  function automatic logic [31:0] zero_bits(input logic fmt, input logic sign);
    return (fmt == FMT_SINGLE) ? {sign, 31'd0} : {16'd0, sign, 15'd0};
  endfunction

  function automatic logic [31:0] inf_bits(input logic fmt, input logic sign);
    return (fmt == FMT_SINGLE) ? {sign, 8'hFF, 23'd0} : {16'd0, sign, 5'h1F, 10'd0};
  endfunction

  function automatic logic [31:0] max_bits(input logic fmt, input logic sign);
    return (fmt == FMT_SINGLE) ? {sign, 8'hFE, 23'h7FFFFF} : {16'd0, sign, 5'h1E, 10'h3FF};
  endfunction

endpackage

// File: hdl/fpu_div_step.sv
// One registered stage of the restoring divider: DIV_BITS quotient bits.
// Depends on fpu_pkg.
module fpu_div_step import fpu_pkg::*; (
  input  logic clk,
  input  div_t d_in,
  output div_t d_out
);

  div_t              step;
  logic [SIG_W+1:0]  diff;

  always_comb begin
    step = d_in;
    diff = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      diff = {1'b0, step.rem} - {2'b00, step.divisor};
      if (!diff[SIG_W+1]) begin
        step.rem = diff[SIG_W:0];
      end
      step.quo = {step.quo[QUO_W-2:0], ~diff[SIG_W+1]};
      step.rem = {step.rem[SIG_W-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    d_out <= step;
  end

endmodule

// File: hdl/fpu_round.sv
// Normalise, round and pack back end: five register stages, last one drives the ports.
// Depends on fpu_pkg.
module fpu_round import fpu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  rnd_in_t     in_data,
  output logic        out_valid,
  output logic [31:0] out_bits
);

  localparam logic [11:0] SH_SP = 12'(RES_W - 1 - MAN_SP);
  localparam logic [11:0] SH_HP = 12'(RES_W - 1 - MAN_HP);
  localparam logic [5:0]  SH_MAX = 6'(RES_W + 1);

  logic             r1_valid, r2_valid, r3_valid, r4_valid;
  rnd_in_t          r1_data;
  logic [5:0]       r1_lz;
  ctl_t             r2_ctl, r3_ctl, r4_ctl;
  logic [RES_W-1:0] r2_sig, r3_sig;
  exp_t             r2_em;
  logic [5:0]       r3_sh;
  logic [9:0]       r3_base, r4_base;
  logic [SIG_W-1:0] r4_q;
  logic             r4_rb, r4_st;

  exp_t             emin;
  exp_t             base_w;
  logic [11:0]      extra;
  logic [11:0]      sh_w;
  logic [5:0]       sh_next;
  logic [9:0]       base_next;

  logic [SIG_W-1:0] q_next;
  logic             rb_next, st_next;

  logic             inc;
  logic [SIG_W:0]   qi;
  logic [10:0]      field;
  logic [10:0]      fmax;
  logic [31:0]      mag;
  logic [31:0]      bits_next;

  // stage 3: right shift that leaves the kept digits, subnormal range included
  always_comb begin
    emin   = (r2_ctl.fmt == FMT_SINGLE) ? -11'sd126 : -11'sd14;
    base_w = r2_em + ((r2_ctl.fmt == FMT_SINGLE) ? 11'sd126 : 11'sd14);
    if (r2_em < emin) begin
      extra     = {emin[EXP_W-1], emin} - {r2_em[EXP_W-1], r2_em};
      base_next = 10'd0;
    end else begin
      extra     = 12'd0;
      base_next = base_w[9:0];
    end
    sh_w    = ((r2_ctl.fmt == FMT_SINGLE) ? SH_SP : SH_HP) + extra;
    sh_next = (sh_w > 12'(SH_MAX)) ? SH_MAX : sh_w[5:0];
  end

  // stage 4: shift with round and sticky bits
  always_comb begin
    q_next  = '0;
    rb_next = 1'b0;
    st_next = 1'b0;
    if (r3_sh == SH_MAX) begin
      st_next = 1'b1;
    end else begin
      q_next  = SIG_W'(r3_sig >> r3_sh);
      rb_next = r3_sig[r3_sh - 6'd1];
      for (int i = 0; i < RES_W; i++) begin
        if (((i + 1) < int'(r3_sh)) && r3_sig[i]) st_next = 1'b1;
      end
    end
  end

  // stage 5: increment, pack and overflow
  always_comb begin
    case (r4_ctl.rm)
      RM_RTZ:  inc = 1'b0;
      RM_RNE:  inc = r4_rb && (r4_st || r4_q[0]);
      RM_RUP:  inc = !r4_ctl.sign && (r4_rb || r4_st);
      RM_RDN:  inc = r4_ctl.sign && (r4_rb || r4_st);
      default: inc = 1'b0;
    endcase
    qi = {1'b0, r4_q} + (SIG_W+1)'(inc);
    if (r4_ctl.fmt == FMT_SINGLE) begin
      field = 11'(r4_base) + 11'(qi >> MAN_SP);
      fmax  = 11'd255;
      mag   = (32'(r4_base) << MAN_SP) + 32'(qi);
    end else begin
      field = 11'(r4_base) + 11'(qi >> MAN_HP);
      fmax  = 11'd31;
      mag   = (32'(r4_base) << MAN_HP) + 32'(qi);
    end
    if (r4_ctl.special) begin
      bits_next = r4_ctl.special_bits;
    end else if (field >= fmax) begin
      case (r4_ctl.rm)
        RM_RTZ:  bits_next = max_bits(r4_ctl.fmt, r4_ctl.sign);
        RM_RNE:  bits_next = inf_bits(r4_ctl.fmt, r4_ctl.sign);
        RM_RUP:  bits_next = r4_ctl.sign ? max_bits(r4_ctl.fmt, 1'b1)
                                         : inf_bits(r4_ctl.fmt, 1'b0);
        RM_RDN:  bits_next = r4_ctl.sign ? inf_bits(r4_ctl.fmt, 1'b1)
                                         : max_bits(r4_ctl.fmt, 1'b0);
        default: bits_next = inf_bits(r4_ctl.fmt, r4_ctl.sign);
      endcase
    end else if (r4_ctl.fmt == FMT_SINGLE) begin
      bits_next = {r4_ctl.sign, mag[30:0]};
    end else begin
      bits_next = {16'd0, r4_ctl.sign, mag[14:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid  <= 1'b0;
      r2_valid  <= 1'b0;
      r3_valid  <= 1'b0;
      r4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      r1_valid  <= in_valid;
      r2_valid  <= r1_valid;
      r3_valid  <= r2_valid;
      r4_valid  <= r3_valid;
      out_valid <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    r1_data  <= in_data;
    r1_lz    <= lzc_res(in_data.sig);
    r2_ctl   <= r1_data.ctl;
    r2_sig   <= r1_data.sig << r1_lz;
    r2_em    <= r1_data.ctl.e_top - exp_t'(r1_lz);
    r3_ctl   <= r2_ctl;
    r3_sig   <= r2_sig;
    r3_sh    <= sh_next;
    r3_base  <= base_next;
    r4_ctl   <= r3_ctl;
    r4_base  <= r3_base;
    r4_q     <= q_next;
    r4_rb    <= rb_next;
    r4_st    <= st_next;
    out_bits <= bits_next;
  end

endmodule

// File: hdl/fp_add_sub_mul_div_unit.sv
// IEEE-754 binary16/binary32 add, subtract, multiply and divide, fully pipelined.
// Depth: the result strobe (done) is driven by the last of 22 register stages;
//   the 14-stage divider sets that depth.
// Throughput: one operation per cycle; busy is high only while rst is asserted.
// Reset (synchronous, rst): clears all valid bits; format to single, rounding to nearest even.
module fp_add_sub_mul_div_unit import fpu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        done,
  output logic [31:0] result_bits,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  // delay line that keeps add/multiply results level with the divider
  localparam int DLY = DIV_STAGES - 2;

  typedef struct packed {
    logic             sign;
    logic [SIG_W-1:0] sig;
    exp_t             e;
  } opnd_t;

  // configuration registers
  logic number_format;
  rm_t  rounding_mode;

  // stage 1: decode and special results
  logic      s1_valid;
  ctl_t      s1_ctl;
  opnd_t     s1_a, s1_b;
  logic [4:0] s1_lza, s1_lzb;

  // stage 2: normalised operands
  logic  s2_valid;
  ctl_t  s2_ctl;
  opnd_t s2_a, s2_b;

  // stage 3: operand ordering and product
  logic             s3_valid;
  ctl_t             s3_ctl;
  logic [SIG_W-1:0] s3_big, s3_small;
  logic [5:0]       s3_d;
  logic             s3_sub;
  logic [PROD_W-1:0] s3_prod;

  // stage 4: aligned sum or placed product
  logic             s4_valid;
  ctl_t             s4_ctl;
  logic [RES_W-1:0] s4_sig;

  logic             dl_valid [DLY];
  ctl_t             dl_ctl   [DLY];
  logic [RES_W-1:0] dl_sig   [DLY];

  div_t div_pipe [DIV_STAGES+1];

  logic    m_valid;
  rnd_in_t m_data;

  logic      accept;
  op_t       op_in;
  logic      sub_in;
  unpacked_t ua, ub;
  logic [31:0] a_bits, b_bits;
  ctl_t      ctl_next;

  opnd_t            big, lesser;
  exp_t             ediff;
  logic             a_ge;
  ctl_t             s3_ctl_next;

  logic [ALIGN_W-1:0] small_wide, small_al;
  logic               sticky;
  logic [RES_W-1:0]   big_res, small_res, s4_sig_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign op_in  = op_t'(operation);
  assign sub_in = (op_in == OP_SUB);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_format <= FMT_SINGLE;
      rounding_mode <= RM_RNE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMAT:   number_format <= cfg_data[0];
        REG_ROUNDING: rounding_mode <= rm_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Decode: take the pattern apart, settle NaN, infinity and zero operands at once.
  always_comb begin
    ua = unpack_op(number_format, operand_a);
    ub = unpack_op(number_format, operand_b);
    // subtract is an add with the second sign flipped
    ub.sign = ub.sign ^ sub_in;
    if (number_format == FMT_SINGLE) begin
      a_bits = operand_a;
      b_bits = {operand_b[31] ^ sub_in, operand_b[30:0]};
    end else begin
      a_bits = {16'd0, operand_a[15:0]};
      b_bits = {16'd0, operand_b[15] ^ sub_in, operand_b[14:0]};
    end
    ctl_next              = '0;
    ctl_next.fmt          = number_format;
    ctl_next.rm           = rounding_mode;
    ctl_next.op           = op_in;
    ctl_next.special      = 1'b1;
    ctl_next.special_bits = qnan_bits(number_format);
    case (op_in)
      OP_ADD, OP_SUB: begin
        if (ua.nan || ub.nan) begin
          ctl_next.special_bits = qnan_bits(number_format);
        end else if (ua.inf && ub.inf) begin
          // opposite infinities cancel to NaN
          ctl_next.special_bits = (ua.sign == ub.sign) ? a_bits : qnan_bits(number_format);
        end else if (ua.inf) begin
          ctl_next.special_bits = a_bits;
        end else if (ub.inf) begin
          ctl_next.special_bits = b_bits;
        end else if (ua.zero && ub.zero) begin
          ctl_next.special_bits = (ua.sign == ub.sign) ? a_bits :
                                  zero_bits(number_format, rounding_mode == RM_RDN);
        end else if (ua.zero) begin
          ctl_next.special_bits = b_bits;
        end else if (ub.zero) begin
          ctl_next.special_bits = a_bits;
        end else begin
          ctl_next.special = 1'b0;
        end
      end
      OP_MUL: begin
        if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ub.inf && ua.zero)) begin
          ctl_next.special_bits = qnan_bits(number_format);
        end else if (ua.inf || ub.inf) begin
          ctl_next.special_bits = inf_bits(number_format, ua.sign ^ ub.sign);
        end else if (ua.zero || ub.zero) begin
          ctl_next.special_bits = zero_bits(number_format, ua.sign ^ ub.sign);
        end else begin
          ctl_next.special = 1'b0;
        end
      end
      default: begin
        if (ua.nan || ub.nan || (ua.zero && ub.zero) || (ua.inf && ub.inf)) begin
          ctl_next.special_bits = qnan_bits(number_format);
        end else if (ua.inf || ub.zero) begin
          // divide by zero gives a signed infinity
          ctl_next.special_bits = inf_bits(number_format, ua.sign ^ ub.sign);
        end else if (ub.inf || ua.zero) begin
          ctl_next.special_bits = zero_bits(number_format, ua.sign ^ ub.sign);
        end else begin
          ctl_next.special = 1'b0;
        end
      end
    endcase
  end

  // Stage 3: order the addends by magnitude; form exponents; multiply.
  always_comb begin
    a_ge = ($signed(s2_a.e) > $signed(s2_b.e)) ||
           ((s2_a.e == s2_b.e) && (s2_a.sig >= s2_b.sig));
    big    = a_ge ? s2_a : s2_b;
    lesser = a_ge ? s2_b : s2_a;
    ediff  = big.e - lesser.e;
    s3_ctl_next = s2_ctl;
    case (s2_ctl.op)
      OP_ADD, OP_SUB: begin
        s3_ctl_next.sign  = big.sign;
        s3_ctl_next.e_top = big.e + 11'sd1;
        // exact cancellation: zero, negative only when rounding down
        if (!s2_ctl.special && (s2_a.sign != s2_b.sign) &&
            (s2_a.sig == s2_b.sig) && (s2_a.e == s2_b.e)) begin
          s3_ctl_next.special      = 1'b1;
          s3_ctl_next.special_bits = zero_bits(s2_ctl.fmt, s2_ctl.rm == RM_RDN);
        end
      end
      OP_MUL: begin
        s3_ctl_next.sign  = s2_a.sign ^ s2_b.sign;
        s3_ctl_next.e_top = s2_a.e + s2_b.e + 11'sd1;
      end
      default: begin
        // first quotient bit carries the weight of the exponent difference
        s3_ctl_next.sign  = s2_a.sign ^ s2_b.sign;
        s3_ctl_next.e_top = s2_a.e - s2_b.e;
      end
    endcase
  end

  // Stage 4: align the smaller addend, fold shifted-out bits into a sticky bit.
  always_comb begin
    small_wide = {s3_small, GUARD_W'(0)};
    small_al   = small_wide >> s3_d;
    sticky     = 1'b0;
    for (int i = 0; i < ALIGN_W; i++) begin
      if ((i < int'(s3_d)) && small_wide[i]) sticky = 1'b1;
    end
    big_res   = {1'b0, s3_big, GUARD_W'(0)};
    small_res = {1'b0, small_al[ALIGN_W-1:1], small_al[0] | sticky};
    if (s3_ctl.op == OP_MUL) begin
      s4_sig_next = {s3_prod, 3'b000};
    end else if (s3_sub) begin
      s4_sig_next = big_res - small_res;
    end else begin
      s4_sig_next = big_res + small_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      for (int i = 0; i < DLY; i++) dl_valid[i] <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      s1_valid    <= accept;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      s4_valid    <= s3_valid;
      dl_valid[0] <= s4_valid;
      for (int i = 1; i < DLY; i++) dl_valid[i] <= dl_valid[i-1];
      m_valid     <= dl_valid[DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl   <= ctl_next;
    s1_a     <= '{sign: ua.sign, sig: ua.sig, e: ua.e23};
    s1_b     <= '{sign: ub.sign, sig: ub.sig, e: ub.e23};
    s1_lza   <= lzc_sig(ua.sig);
    s1_lzb   <= lzc_sig(ub.sig);
    // normalise subnormal operands
    s2_ctl   <= s1_ctl;
    s2_a     <= '{sign: s1_a.sign, sig: s1_a.sig << s1_lza, e: s1_a.e - exp_t'(s1_lza)};
    s2_b     <= '{sign: s1_b.sign, sig: s1_b.sig << s1_lzb, e: s1_b.e - exp_t'(s1_lzb)};
    s3_ctl   <= s3_ctl_next;
    s3_big   <= big.sig;
    s3_small <= lesser.sig;
    s3_d     <= (ediff > 11'sd63) ? 6'd63 : ediff[5:0];
    s3_sub   <= s2_a.sign != s2_b.sign;
    s3_prod  <= s2_a.sig * s2_b.sig;
    s4_ctl   <= s3_ctl;
    s4_sig   <= s4_sig_next;
    dl_ctl[0] <= s4_ctl;
    dl_sig[0] <= s4_sig;
    for (int i = 1; i < DLY; i++) begin
      dl_ctl[i] <= dl_ctl[i-1];
      dl_sig[i] <= dl_sig[i-1];
    end
    // merge: quotient with remainder sticky, or the delayed sum/product
    m_data.ctl <= dl_ctl[DLY-1];
    if (dl_ctl[DLY-1].op == OP_DIV) begin
      m_data.sig <= {div_pipe[DIV_STAGES].quo, div_pipe[DIV_STAGES].rem != '0,
                     (RES_W-QUO_W-1)'(0)};
    end else begin
      m_data.sig <= dl_sig[DLY-1];
    end
  end

  // Divider: normalised dividend over normalised divisor, DIV_BITS bits per stage.
  assign div_pipe[0] = '{divisor: s2_b.sig, rem: {1'b0, s2_a.sig}, quo: '0};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    fpu_div_step u_step (
      .clk   (clk),
      .d_in  (div_pipe[k]),
      .d_out (div_pipe[k+1])
    );
  end

  fpu_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_data   (m_data),
    .out_valid (done),
    .out_bits  (result_bits)
  );

`ifndef SYNTH
  // every accepted transfer gives exactly one result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##22 done)
    else $error("result missing after accepted operation");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 22))
    else $error("result without matching operation");

  a_qnan: assert property (@(posedge clk) disable iff (rst)
    (done && (result_bits[30:23] == 8'hFF) && (result_bits[22:0] != 23'd0))
      |-> (result_bits == QNAN_SP))
    else $error("non-canonical NaN produced");
`endif

endmodule

// File: tb/sv/fp_add_sub_mul_div_unit_tb.sv
// Self-checking testbench for fp_add_sub_mul_div_unit: directed corner cases, then random
// operations under every format and rounding setting, checked against a bit-exact predictor.
// Depends on fpu_pkg and the fp_add_sub_mul_div_unit RTL.
module fp_add_sub_mul_div_unit_tb;
  import fpu_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        done;
  logic [31:0] result_bits;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [1:0]  cfg_data;

  fp_add_sub_mul_div_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
    .done(done), .result_bits(result_bits),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // One directed row: the setting it runs under, the operation and, where the answer
  // is plain to see, the result typed in by hand.
  typedef struct packed {
    logic        fmt;
    rm_t         rm;
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    logic [31:0] res;
  } corner_row_t;

  // Operand split into sign, exponent field, significand and weight: value = g * 2^e.
  typedef struct {
    bit                 s;
    int                 fld;
    longint unsigned    g;
    int                 e;
  } fp_parts_t;

  localparam int N_CORNERS = 26;
  localparam int LATENCY   = 21;

  corner_row_t corner_rows [N_CORNERS] = '{
    '{FMT_SINGLE, RM_RNE, OP_ADD, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000},
    '{FMT_SINGLE, RM_RNE, OP_ADD, 32'h7FC0_0001, 32'h3F80_0000, 1'b1, QNAN_SP},
    '{FMT_SINGLE, RM_RNE, OP_SUB, 32'h7F80_0000, 32'h7F80_0000, 1'b1, QNAN_SP},
    '{FMT_SINGLE, RM_RNE, OP_MUL, 32'h0000_0000, 32'h7F80_0000, 1'b1, QNAN_SP},
    '{FMT_SINGLE, RM_RNE, OP_DIV, 32'h0000_0000, 32'h8000_0000, 1'b1, QNAN_SP},
    '{FMT_SINGLE, RM_RNE, OP_DIV, 32'h7F80_0000, 32'hFF80_0000, 1'b1, QNAN_SP},
    '{FMT_SINGLE, RM_RNE, OP_DIV, 32'h3F80_0000, 32'h8000_0000, 1'b1, 32'hFF80_0000},
    '{FMT_SINGLE, RM_RNE, OP_DIV, 32'h3F80_0000, 32'h7F80_0000, 1'b1, 32'h0000_0000},
    '{FMT_SINGLE, RM_RNE, OP_DIV, 32'h8000_0000, 32'h3F80_0000, 1'b1, 32'h8000_0000},
    '{FMT_SINGLE, RM_RNE, OP_DIV, 32'hFFFF_FFFF, 32'h3F80_0000, 1'b1, QNAN_SP},
    '{FMT_SINGLE, RM_RNE, OP_MUL, 32'h7F7F_FFFF, 32'h4000_0000, 1'b1, 32'h7F80_0000},
    '{FMT_SINGLE, RM_RNE, OP_MUL, 32'h3EAA_AAAB, 32'h4049_0FDB, 1'b0, 32'h0},
    '{FMT_SINGLE, RM_RNE, OP_MUL, 32'h0000_0001, 32'h3F00_0000, 1'b1, 32'h0000_0000},
    '{FMT_SINGLE, RM_RNE, OP_ADD, 32'h0000_0001, 32'h8000_0001, 1'b1, 32'h0000_0000},
    '{FMT_SINGLE, RM_RTZ, OP_MUL, 32'h7F7F_FFFF, 32'h4000_0000, 1'b1, 32'h7F7F_FFFF},
    '{FMT_SINGLE, RM_RUP, OP_MUL, 32'hFF7F_FFFF, 32'h4000_0000, 1'b1, 32'hFF7F_FFFF},
    '{FMT_SINGLE, RM_RUP, OP_MUL, 32'h0000_0001, 32'h3F00_0000, 1'b1, 32'h0000_0001},
    '{FMT_SINGLE, RM_RDN, OP_MUL, 32'h7F7F_FFFF, 32'h4000_0000, 1'b1, 32'h7F7F_FFFF},
    '{FMT_SINGLE, RM_RDN, OP_SUB, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h8000_0000},
    '{FMT_SINGLE, RM_RDN, OP_ADD, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{FMT_HALF,   RM_RNE, OP_ADD, 32'hFFFF_3C00, 32'h0000_3C00, 1'b1, 32'h0000_4000},
    '{FMT_HALF,   RM_RNE, OP_MUL, 32'h0000_7BFF, 32'h0000_4000, 1'b1, 32'h0000_7C00},
    '{FMT_HALF,   RM_RNE, OP_DIV, 32'h0000_0001, 32'h0000_4000, 1'b1, 32'h0000_0000},
    '{FMT_HALF,   RM_RNE, OP_ADD, 32'h0000_3555, 32'hA5A5_0400, 1'b0, 32'h0},
    '{FMT_HALF,   RM_RTZ, OP_MUL, 32'h0000_7BFF, 32'h0000_4000, 1'b1, 32'h0000_7BFF},
    '{FMT_HALF,   RM_RUP, OP_DIV, 32'h0000_0001, 32'h0000_C000, 1'b1, 32'h0000_8000}
  };

  // Predictor copy of the two registers and the format constants they imply.
  logic fmt_now;
  rm_t  rm_now;
  int   man_w, exp_w, bias_v, exp_all;
  logic [31:0] width_mask, qnan_now;

  logic [31:0] pending_results [$];
  int errors, sent, checked, settings;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int top_bit(longint unsigned v);
    int p;
    p = 0;
    while (v >> 1) begin
      v >>= 1;
      p++;
    end
    return p;
  endfunction

  function automatic logic [31:0] with_sign(bit s, logic [31:0] mag);
    return mag | (32'(s) << (man_w + exp_w));
  endfunction

  function automatic fp_parts_t split_operand(logic [31:0] bits);
    fp_parts_t r;
    longint unsigned frac;
    frac  = longint'(bits) & ((64'd1 << man_w) - 1);
    r.s   = bits[man_w + exp_w];
    r.fld = int'((bits >> man_w) & exp_all);
    if (r.fld == 0) begin
      r.g = frac;
      r.e = 1 - bias_v - man_w;
    end else begin
      r.g = frac | (64'd1 << man_w);
      r.e = r.fld - bias_v - man_w;
    end
    return r;
  endfunction

  function automatic logic [31:0] overflow_value(bit s);
    logic [31:0] inf, mx, mag;
    inf = 32'(exp_all) << man_w;
    mx  = inf - 1;
    case (rm_now)
      RM_RTZ:  mag = mx;
      RM_RNE:  mag = inf;
      RM_RUP:  mag = s ? mx : inf;
      default: mag = s ? inf : mx;
    endcase
    return with_sign(s, mag);
  endfunction

  // Round sig * 2^e once under the current mode and encode it.
  function automatic logic [31:0] round_encode(bit s, int e, longint unsigned sig);
    int p, lo, sh;
    longint unsigned q;
    bit rb, st, inc;
    longint base, fld;
    p  = top_bit(sig);
    lo = 1 - bias_v - man_w;
    sh = p - man_w;
    rb = 0;
    st = 0;
    if (lo - e > sh) sh = lo - e;
    if (sh <= 0) begin
      q = sig << (-sh);
    end else if (sh > 63) begin
      q  = 0;
      st = 1;
    end else begin
      q  = sig >> sh;
      rb = 1'((sig >> (sh - 1)) & 1);
      if (sh > 1) st = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
    end
    case (rm_now)
      RM_RTZ:  inc = 0;
      RM_RNE:  inc = rb && (st || q[0]);
      RM_RUP:  inc = !s && (rb || st);
      default: inc = s && (rb || st);
    endcase
    q    = q + inc;
    base = longint'(e) + sh + man_w + bias_v - 1;
    fld  = base + longint'(q >> man_w);
    if (fld >= exp_all) return overflow_value(s);
    return with_sign(s, 32'(($unsigned(base) << man_w) + q));
  endfunction

  function automatic logic [31:0] exact_zero();
    return with_sign(rm_now == RM_RDN, 32'd0);
  endfunction

  function automatic logic [31:0] sum_value(logic [31:0] a, logic [31:0] b);
    fp_parts_t pa, pb, t;
    longint unsigned fm, big, sml;
    int d;
    fm = (64'd1 << man_w) - 1;
    pa = split_operand(a);
    pb = split_operand(b);
    if ((pa.fld == exp_all && (pa.g & fm) != 0) || (pb.fld == exp_all && (pb.g & fm) != 0))
      return qnan_now;
    if (pa.fld == exp_all && pb.fld == exp_all) return (pa.s == pb.s) ? a : qnan_now;
    if (pa.fld == exp_all) return a;
    if (pb.fld == exp_all) return b;
    if (pa.g == 0 && pb.g == 0) return (pa.s == pb.s) ? a : exact_zero();
    if (pa.g == 0) return b;
    if (pb.g == 0) return a;
    if (pa.e < pb.e) begin
      t  = pa;
      pa = pb;
      pb = t;
    end
    d   = pa.e - pb.e;
    big = pa.g << 36;
    if (d <= 36) sml = pb.g << (36 - d);
    else if (d - 36 >= 64) sml = 1;
    else sml = (pb.g >> (d - 36)) | 64'((pb.g & ((64'd1 << (d - 36)) - 1)) != 0);
    if (pa.s == pb.s) return round_encode(pa.s, pa.e - 36, big + sml);
    if (big == sml) return exact_zero();
    if (big > sml) return round_encode(pa.s, pa.e - 36, big - sml);
    return round_encode(pb.s, pa.e - 36, sml - big);
  endfunction

  function automatic logic [31:0] product_quotient(logic [31:0] a, logic [31:0] b, bit dv);
    fp_parts_t pa, pb;
    longint unsigned fm, inf, num;
    bit s, ia, ib, za, zb;
    int sh;
    fm = (64'd1 << man_w) - 1;
    pa = split_operand(a);
    pb = split_operand(b);
    if ((pa.fld == exp_all && (pa.g & fm) != 0) || (pb.fld == exp_all && (pb.g & fm) != 0))
      return qnan_now;
    s   = pa.s ^ pb.s;
    inf = 64'(exp_all) << man_w;
    ia  = pa.fld == exp_all;
    ib  = pb.fld == exp_all;
    za  = pa.g == 0;
    zb  = pb.g == 0;
    if (!dv) begin
      if ((ia && zb) || (ib && za)) return qnan_now;
      if (ia || ib) return with_sign(s, 32'(inf));
      if (za || zb) return with_sign(s, 32'd0);
      return round_encode(s, pa.e + pb.e, pa.g * pb.g);
    end
    if ((za && zb) || (ia && ib)) return qnan_now;
    if (ia || zb) return with_sign(s, 32'(inf));
    if (ib || za) return with_sign(s, 32'd0);
    sh  = 60 - top_bit(pa.g);
    num = pa.g << sh;
    return round_encode(s, pa.e - sh - pb.e, (num / pb.g) | 64'((num % pb.g) != 0));
  endfunction

  function automatic logic [31:0] fp_result(op_t op, logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    a = a & width_mask;
    b = b & width_mask;
    case (op)
      OP_ADD:  r = sum_value(a, b);
      OP_SUB:  r = sum_value(a, b ^ (32'd1 << (man_w + exp_w)));
      OP_MUL:  r = product_quotient(a, b, 1'b0);
      default: r = product_quotient(a, b, 1'b1);
    endcase
    return r & width_mask;
  endfunction

  // Random operand biased towards the interesting exponent fields.
  function automatic logic [31:0] pick_operand();
    int fld, sel;
    logic [31:0] frac, bits;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:    fld = 0;
      2:       fld = exp_all;
      3:       fld = 1;
      4:       fld = exp_all - 1;
      5, 6:    fld = bias_v - 3 + $urandom_range(0, 6);
      default: fld = $urandom_range(0, exp_all);
    endcase
    frac = $urandom & ((32'd1 << man_w) - 1);
    sel  = $urandom_range(0, 7);
    if (sel < 2) frac = 0;
    else if (sel == 2) frac = (32'd1 << man_w) - 1;
    bits = with_sign(1'($urandom_range(0, 1)), (32'(fld) << man_w) | frac);
    // half format ignores the upper bits; keep them toggling anyway
    if (fmt_now == FMT_HALF) bits = bits | ($urandom << 16);
    return bits;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit and result checking
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("fp_add_sub_mul_div_unit: mismatch");
    $finish;
  end

  // Results cannot be held off: compare every strobed result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result_bits: none expected, got %h", result_bits);
        errors++;
      end else begin
        if (result_bits !== pending_results[0]) begin
          $error("result_bits: expected %h, got %h", pending_results[0], result_bits);
          errors++;
        end
        void'(pending_results.pop_front());
        checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------
  // Hold start high until the transfer is taken, then record its expectation.
  task automatic send_op(op_t op, logic [31:0] a, logic [31:0] b, bit typed,
                         logic [31:0] typed_res);
    @(negedge clk);
    start     <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? typed_res : fp_result(op, a, b));
    sent++;
  endtask

  task automatic idle_burst(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop start, wait for every outstanding result, then let the pipeline settle.
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Change the block's setting only when idle; track it in the predictor copy.
  task automatic apply_setting(logic fmt, rm_t rm);
    drain_pipe();
    write_reg(REG_FORMAT, {1'b0, fmt});
    write_reg(REG_ROUNDING, rm);
    fmt_now    = fmt;
    rm_now     = rm;
    man_w      = (fmt == FMT_SINGLE) ? MAN_SP : MAN_HP;
    exp_w      = (fmt == FMT_SINGLE) ? 8 : 5;
    bias_v     = (fmt == FMT_SINGLE) ? 127 : 15;
    exp_all    = (fmt == FMT_SINGLE) ? 255 : 31;
    width_mask = (fmt == FMT_SINGLE) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    qnan_now   = (fmt == FMT_SINGLE) ? QNAN_SP : QNAN_HP;
    settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] a, b;
    op_t op;
    bit quiet;
    rst       = 1'b1;
    start     = 1'b0;
    operation = OP_ADD;
    operand_a = '0;
    operand_b = '0;
    cfg_write = 1'b0;
    cfg_index = REG_FORMAT;
    cfg_data  = '0;
    errors    = 0;
    sent      = 0;
    checked   = 0;
    settings  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners: rewrite the registers whenever a row asks for a new setting.
    apply_setting(FMT_SINGLE, RM_RNE);
    foreach (corner_rows[i]) begin
      if (corner_rows[i].fmt !== fmt_now || corner_rows[i].rm !== rm_now)
        apply_setting(corner_rows[i].fmt, corner_rows[i].rm);
      send_op(corner_rows[i].op, corner_rows[i].a, corner_rows[i].b,
              corner_rows[i].typed, corner_rows[i].res);
    end

    // Random phase: every format and rounding mode, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(ph[0], rm_t'(ph[2:1]));
      quiet = (ph == 7);  // last setting runs back to back
      for (int n = 0; n < 60; n++) begin
        if (!quiet && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 15));
        op = op_t'($urandom_range(0, 3));
        a  = pick_operand();
        b  = pick_operand();
        // near cancellation: b close to a, flipping its sign for add
        if ((op == OP_ADD || op == OP_SUB) && $urandom_range(0, 4) == 0) begin
          b = a ^ ($urandom & 32'h7);
          if (op == OP_ADD) b = b ^ (32'd1 << (man_w + exp_w));
        end
        send_op(op, a, b, 1'b0, 32'd0);
      end
    end

    drain_pipe();
    $display("%0d operations sent and %0d results checked over %0d format/rounding settings",
             sent, checked, settings);
    if (errors == 0) begin
      $display("fp_add_sub_mul_div_unit: match");
    end else begin
      $display("fp_add_sub_mul_div_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/fpu_pkg.sv
hdl/fpu_div_step.sv
hdl/fpu_round.sv
hdl/fp_add_sub_mul_div_unit.sv
tb/sv/fp_add_sub_mul_div_unit_tb.sv
